[rtl/core/exp_taylor_horner_defines.svh]
// Assertion macros for the exp_taylor_horner RTL.
`ifndef EXP_TAYLOR_HORNER_DEFINES_SVH
`define EXP_TAYLOR_HORNER_DEFINES_SVH

// Same-cycle implication, checked on clk, masked during rst.
`define ETH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, masked during rst.
`define ETH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/exp_th_pkg.sv]
// Shared types and widths for the Taylor-series exponential block.
`timescale 1ns / 1ps
package exp_th_pkg;

  localparam int X_W     = 5;    // exponent argument
  localparam int K_W     = 5;    // term index / term count
  localparam int WORD_W  = 57;   // Q24.32 result word
  localparam int PROD_W  = 62;   // x * r, holds +2^60
  localparam int SUM_W   = 63;   // one + quotient before clamp
  localparam int QMAG_W  = 61;   // quotient magnitude bits
  localparam int DVD_W   = 64;   // divider dividend, padded
  localparam int DIV_BPC = 8;    // quotient bits per divider cycle
  localparam int DIV_CYC = DVD_W / DIV_BPC;
  localparam int DCNT_W  = $clog2(DIV_CYC);

  typedef struct packed {
    logic           load;       // capture x, reset accumulator and flag
    logic           mul;        // register x * r
    logic           div_start;  // launch |x * r| / k
    logic           upd;        // r <= clamp(one + quotient)
    logic [K_W-1:0] k;          // current divisor
  } eth_cmd_t;

  typedef struct packed {
    logic div_done;
  } eth_status_t;

endpackage

[rtl/core/exp_th_div.sv]
// Unsigned divider by a small divisor, DIV_BPC quotient bits per cycle.
`timescale 1ns / 1ps
module exp_th_div
  import exp_th_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [K_W-1:0]   divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  logic              run;
  logic [DCNT_W-1:0] cnt;
  logic [K_W-1:0]    rem;
  logic [DVD_W-1:0]  dvd;
  logic [K_W:0]      rem_next;
  logic [DVD_W-1:0]  dvd_next;

  // Restoring division; remainder stays below divisor so it is narrow.
  always_comb begin
    rem_next = {1'b0, rem};
    dvd_next = dvd;
    for (int i = 0; i < DIV_BPC; i++) begin
      rem_next = {rem_next[K_W-1:0], dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (rem_next >= {1'b0, divisor}) begin
        rem_next    = rem_next - {1'b0, divisor};
        dvd_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_CYC - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (run) begin
      dvd <= dvd_next;
      rem <= rem_next[K_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

[rtl/core/exp_th_dp.sv]
// Datapath: argument, accumulator, product, divider and saturating update.
`timescale 1ns / 1ps
module exp_th_dp
  import exp_th_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  eth_cmd_t                 cmd,
  output eth_status_t              status,
  input  logic signed [X_W-1:0]    x_value,
  output logic signed [WORD_W-1:0] exp_value,
  output logic                     saturated
);

  localparam logic [WORD_W-1:0] FIX_ONE = {{(WORD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [X_W-1:0]    held_argument;
  logic signed [WORD_W-1:0] accumulator;
  logic                     sat;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0]        prod_mag;
  logic [DVD_W-1:0]         quotient;
  logic signed [SUM_W-1:0]  quot_s;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-WORD_W:0]    sum_hi;
  logic                     ovf;
  logic signed [WORD_W-1:0] clamped;

  assign prod_next = held_argument * accumulator;
  assign prod_mag  = prod[PROD_W-1] ? -prod : prod;

  exp_th_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({{(DVD_W-PROD_W){1'b0}}, prod_mag}),
    .divisor  (cmd.k),
    .quotient (quotient),
    .done     (status.div_done)
  );

  // Quotient takes the product's sign: truncation toward zero.
  always_comb begin
    quot_s = {{(SUM_W-QMAG_W){1'b0}}, quotient[QMAG_W-1:0]};
    if (prod[PROD_W-1]) quot_s = -quot_s;
    sum    = quot_s + {{(SUM_W-WORD_W){1'b0}}, FIX_ONE};
    sum_hi = sum[SUM_W-1:WORD_W-1];
    ovf    = (sum_hi != '0) && (sum_hi != '1);
    if (!ovf) clamped = sum[WORD_W-1:0];
    else if (sum[SUM_W-1]) clamped = {1'b1, {(WORD_W-1){1'b0}}};
    else clamped = {1'b0, {(WORD_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (cmd.load) begin
      sat <= 1'b0;
    end else if (cmd.upd) begin
      sat <= sat | ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_argument <= '0;
      accumulator   <= FIX_ONE;
    end else if (cmd.load) begin
      held_argument <= x_value;
      accumulator   <= FIX_ONE;
    end else if (cmd.upd) begin
      accumulator <= clamped;
    end
    if (cmd.mul) prod <= prod_next;
  end

  assign exp_value = accumulator;
  assign saturated = sat;

endmodule

[rtl/core/exp_th_ctrl.sv]
// Controller: Horner term sequencing, one multiply and one divide per term.
`timescale 1ns / 1ps
module exp_th_ctrl
  import exp_th_pkg::*;
#(
  parameter int MAX_TERMS = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [K_W-1:0] term_count,
  input  eth_status_t    status,
  output eth_cmd_t       cmd,
  output logic           busy,
  output logic           done
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [K_W-1:0] TERMS_CAP = K_W'(MAX_TERMS);

  logic [2:0]     state, state_next;
  logic [K_W-1:0] term_index, term_index_next;
  logic [K_W-1:0] n_eff;

  assign n_eff = (term_count > TERMS_CAP) ? TERMS_CAP : term_count;

  always_comb begin
    state_next      = state;
    term_index_next = term_index;
    cmd             = '0;
    cmd.k           = term_index;
    busy            = 1'b1;
    done            = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (n_eff == '0) begin
            state_next = S_DONE;
          end else begin
            term_index_next = n_eff;
            state_next      = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.upd = 1'b1;
          if (term_index == K_W'(1)) begin
            term_index_next = '0;
            state_next      = S_DONE;
          end else begin
            term_index_next = term_index - 1'b1;
            state_next      = S_MUL;
          end
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      term_index <= '0;
    end else begin
      state      <= state_next;
      term_index <= term_index_next;
    end
  end

endmodule

[rtl/core/exp_taylor_horner.sv]
// Top level of the Taylor-series exponential: APB register, controller, datapath.
`timescale 1ns / 1ps
// exp_taylor_horner computes e^x for a 5-bit signed integer x as the Taylor
// series truncated after term_count terms, by Horner's rule:
// r = 1, then for k = n down to 1, r = 1 + trunc((x * r) / k), in signed
// Q24.32 (FRAC_BITS fraction bits) in a 57-bit word, clamped to that word
// after every step; saturated reports any clamp. n is term_count capped at
// MAX_TERMS. A transaction is accepted when start is high and busy is low;
// its result appears on exp_value/saturated for exactly one cycle with done
// high, and there is no backpressure, so the receiver must take it then.
// Each term steps through the product register, the divider launch, the
// iterations of the 8-bit-per-cycle divider and the update; a transaction
// ends with done before busy drops and the next one can be accepted. The
// shared multiplier and the iterative divider set how long a term lasts. Write
// term_count (address 0, reset 10) only while busy is low.
`include "exp_taylor_horner_defines.svh"
module exp_taylor_horner
  import exp_th_pkg::*;
#(
  parameter int MAX_TERMS = 20,
  parameter int FRAC_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [X_W-1:0]    x_value,
  // result strobe
  output logic                     done,
  output logic signed [WORD_W-1:0] exp_value,
  output logic                     saturated,
  // APB configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic REG_TERM_COUNT = 1'b0;  // word index of term_count

  logic [K_W-1:0] term_count;
  logic           cfg_write;
  eth_cmd_t       cmd;
  eth_status_t    status;

  // Config transaction completes on the access phase; pready never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= K_W'(10);
    end else if (cfg_write && paddr[2] == REG_TERM_COUNT) begin
      term_count <= pwdata[K_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TERM_COUNT) ? {{(32-K_W){1'b0}}, term_count} : '0;

  exp_th_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .term_count (term_count),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  exp_th_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .x_value   (x_value),
    .exp_value (exp_value),
    .saturated (saturated)
  );

  // Result strobe only comes out of an active transaction, and ends it.
  `ETH_ASSERT_NOW(a_done_busy, done, busy, "done without busy")
  `ETH_ASSERT_NEXT(a_done_idle, done, !busy, "busy held after done")
  `ETH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
  // Zero terms: result is exactly one, the very next cycle.
  `ETH_ASSERT_NEXT(a_zero_terms, start && !busy && term_count == '0,
    done && !saturated && exp_value == ({{(WORD_W-1){1'b0}}, 1'b1} << FRAC_BITS),
    "zero-term transaction gave wrong result")

endmodule

[tb/exp_taylor_horner_tb.sv]
// Self-checking testbench for the Taylor-series exponential block exp_taylor_horner.
`timescale 1ns / 1ps
// Flow: reset, a short directed table (term count extremes, argument extremes,
// capped counts, a write to an unused address), then random phases. Each phase
// waits for the block to go idle, rewrites term_count over APB, and runs a
// batch of random arguments with random or no gaps between transactions.
// Every accepted transaction is predicted by a local Horner evaluator, or by the
// typed value of a fixed row, and queued; each done strobe checks the oldest entry.
module exp_taylor_horner_tb;
  import exp_th_pkg::*;

  localparam int MAX_TERMS = 20;
  localparam int FRAC_BITS = 32;
  localparam int ITEM_GOAL = 650;
  // Far above the slowest transaction plus the longest random gap between sends.
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;

  localparam logic [2:0] ADDR_TERM_COUNT = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;  // register index 1: writes ignored

  localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;
  localparam longint WORD_MAX = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
  localparam longint WORD_MIN = -WORD_MAX - 64'sd1;

  typedef struct packed {
    logic [K_W-1:0] tc;               // term_count for this row
    logic stray;                      // write the unused address first
    logic signed [X_W-1:0] x;
    logic fixed;                      // expected value typed in below
    logic signed [WORD_W-1:0] want;
    logic want_sat;
  } dir_row_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic sat;
  } exp_result_t;

  localparam int DIR_ROWS = 23;
  // Fixed expectations only where the series is trivial: zero terms or a zero
  // argument gives exactly one, one term gives 1 + x, two terms 1 + x + x*x/2.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{5'd10, 1'b0,  5'sd0,  1'b1, 57'sd4294967296,   1'b0},  // reset count
    '{5'd10, 1'b0,  5'sd1,  1'b0, 57'sd0,            1'b0},
    '{5'd10, 1'b0, -5'sd1,  1'b0, 57'sd0,            1'b0},
    '{5'd10, 1'b0,  5'sd15, 1'b0, 57'sd0,            1'b0},
    '{5'd10, 1'b0, -5'sd16, 1'b0, 57'sd0,            1'b0},
    '{5'd0,  1'b0,  5'sd0,  1'b1, 57'sd4294967296,   1'b0},  // zero terms
    '{5'd0,  1'b0,  5'sd15, 1'b1, 57'sd4294967296,   1'b0},
    '{5'd0,  1'b0, -5'sd16, 1'b1, 57'sd4294967296,   1'b0},
    '{5'd1,  1'b0,  5'sd0,  1'b1, 57'sd4294967296,   1'b0},
    '{5'd1,  1'b0,  5'sd1,  1'b1, 57'sd8589934592,   1'b0},
    '{5'd1,  1'b0, -5'sd1,  1'b1, 57'sd0,            1'b0},
    '{5'd1,  1'b0,  5'sd15, 1'b1, 57'sd68719476736,  1'b0},
    '{5'd1,  1'b0, -5'sd16, 1'b1, -57'sd64424509440, 1'b0},
    '{5'd2,  1'b0,  5'sd1,  1'b1, 57'sd10737418240,  1'b0},  // 2.5
    '{5'd2,  1'b0, -5'sd1,  1'b1, 57'sd2147483648,   1'b0},  // 0.5
    '{5'd20, 1'b0,  5'sd15, 1'b0, 57'sd0,            1'b0},  // max terms
    '{5'd20, 1'b0, -5'sd16, 1'b0, 57'sd0,            1'b0},
    '{5'd20, 1'b0,  5'sd7,  1'b0, 57'sd0,            1'b0},
    '{5'd21, 1'b0,  5'sd15, 1'b0, 57'sd0,            1'b0},  // count capped
    '{5'd31, 1'b0, -5'sd16, 1'b0, 57'sd0,            1'b0},
    '{5'd31, 1'b0,  5'sd10, 1'b0, 57'sd0,            1'b0},
    '{5'd31, 1'b1,  5'sd3,  1'b0, 57'sd0,            1'b0},  // unused address
    '{5'd19, 1'b0, -5'sd5,  1'b0, 57'sd0,            1'b0}
  };

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [X_W-1:0] x_value;
  logic done;
  logic signed [WORD_W-1:0] exp_value;
  logic saturated;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // local copy of the block's register
  logic [K_W-1:0] term_count_q;

  exp_result_t pending_q[$];
  int mismatches;
  int items_sent;
  int idle_cycles;

  exp_taylor_horner #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_value(x_value),
    .done(done),
    .exp_value(exp_value),
    .saturated(saturated),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Horner evaluation: r = 1, then r = clamp(1 + trunc(x*r / k)) for k = n..1.
  // SV signed division already truncates toward zero.
  function automatic exp_result_t horner_exp(input logic signed [X_W-1:0] x,
                                             input logic [K_W-1:0] terms);
    exp_result_t res;
    longint r;
    longint xs;
    int n;
    r = Q_ONE;
    xs = x;
    res.sat = 1'b0;
    n = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
    for (int k = n; k >= 1; k--) begin
      r = Q_ONE + (xs * r) / longint'(k);
      if (r > WORD_MAX) begin
        r = WORD_MAX;
        res.sat = 1'b1;
      end else if (r < WORD_MIN) begin
        r = WORD_MIN;
        res.sat = 1'b1;
      end
    end
    res.value = r[WORD_W-1:0];
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TERM_COUNT) term_count_q = data[K_W-1:0];
    @(negedge clk);
    // read back the register through prdata
    if (addr == ADDR_TERM_COUNT && prdata !== {27'h0, term_count_q})
      report_mismatch($sformatf("prdata got %0d want %0d", prdata, term_count_q));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop start and wait until every result is in and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Issue one transaction, holding start low first when `gap` is nonzero. start
  // stays high on return so a back-to-back transaction needs no extra edge on it.
  task automatic send_x(input logic signed [X_W-1:0] x, input int gap,
                        input logic fixed, input exp_result_t fixed_res);
    exp_result_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    x_value <= x;
    do @(posedge clk); while (busy);
    // accepted at this edge
    res = horner_exp(x, term_count_q);
    pending_q.push_back(fixed ? fixed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  // Result checker: one done cycle is one transaction, no backpressure.
  always @(posedge clk) begin
    exp_result_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result exp_value=%0d saturated=%0b",
                                  exp_value, saturated));
      end else begin
        want = pending_q.pop_front();
        if (exp_value !== want.value)
          report_mismatch($sformatf("exp_value got %0d want %0d",
                                    exp_value, want.value));
        if (saturated !== want.sat)
          report_mismatch($sformatf("saturated got %0b want %0b",
                                    saturated, want.sat));
      end
    end
  end

  // Watchdog: too long without any transaction moving on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    exp_result_t fixed_res;
    dir_row_t row;
    logic [K_W-1:0] tc;
    logic signed [X_W-1:0] x;
    int batch;
    int pick;
    bit no_gaps;
    rst = 1'b1;
    start = 1'b0;
    x_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    items_sent = 0;
    term_count_q = 5'd10;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. Config changes happen only with the block idle.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.tc != term_count_q || row.stray) begin
        wait_idle();
        if (row.tc != term_count_q) apb_write(ADDR_TERM_COUNT, {27'h0, row.tc});
        if (row.stray) apb_write(ADDR_UNUSED, 32'h0000_0005);
      end
      fixed_res.value = row.want;
      fixed_res.sat = row.want_sat;
      send_x(row.x, $urandom_range(0, 2), row.fixed, fixed_res);
    end

    // Random phases: new term count, then a batch of arguments.
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 15) tc = 5'd0;
      else if (pick < 30) tc = 5'd20;
      else if (pick < 40) tc = 5'd31;
      else tc = K_W'($urandom_range(0, 31));
      // junk in the upper data bits must not matter
      apb_write(ADDR_TERM_COUNT, {27'($urandom()), tc});
      if ($urandom_range(0, 7) == 0) apb_write(ADDR_UNUSED, $urandom());
      no_gaps = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(8, 40);
      for (int j = 0; j < batch; j++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) x = -5'sd16;
        else if (pick == 1) x = 5'sd15;
        else x = X_W'($urandom_range(0, 31));
        send_x(x, no_gaps ? 0 : $urandom_range(0, 8), 1'b0, fixed_res);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
